>>> design/cosine_topk_search_core_macros.svh
// Assertion macros shared by the cosine top-k search RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef COSINE_TOPK_SEARCH_CORE_MACROS_SVH
`define COSINE_TOPK_SEARCH_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cts check failed");
`define CTS_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("cts forbidden condition seen");
`else
`define CTS_ASSERT(lbl, clk, rstn, prop)
`define CTS_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

>>> design/cts_pkg.sv
// Shared types and constants of the cosine top-k search block.
// Used by cts_ctrl, cts_dp and the top level; depends on nothing.
`default_nettype none
package cts_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_K       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION   = 2'd2;

  localparam int unsigned DIV_STEPS = 15;
  localparam logic signed [15:0] SCORE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SCORE_MIN = 16'sh8000;

  typedef struct packed {
    logic vec_we;
    logic qry_we;
    logic qmode;
    logic iss;
    logic acc_clr;
    logic qn_clr;
    logic sqrt_start;
    logic sqrt_step;
    logic qroot_ld;
    logic den_ld;
    logic div_init;
    logic div_step;
    logic score_we;
    logic force_zero;
    logic taken_clr;
    logic scan_clr;
    logic scan_iss;
    logic emit;
    logic final_res;
  } cmd_t;

  typedef struct packed {
    logic acc_busy;
    logic sqrt_done;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

>>> design/cosine_topk_search_core.sv
// Top level of the cosine top-k search: joins cts_ctrl and cts_dp.
// Depends on cts_pkg and cosine_topk_search_core_macros.svh.
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_stall_o  | op, entry, element, value, last
//   out     | output    | out_valid_o / out_stall_i| match_index, score, rank, final_res
//   cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// Load items and non-last query items are accepted without stalling.
// A last query item starts a search: the query norm, then a score for each of
// the N entries (zero for all if the dimension is invalid), then K ranking scans
// for K results. The square root has S = 21 steps at default widths; the
// shared multiply pipeline, square root and divider do the work.
// Reset returns all control state to its defaults; stored vectors are undefined until loaded.
// Input stays stalled for the whole search; a stalled output holds the search.
`default_nettype none
`include "cosine_topk_search_core_macros.svh"
module cosine_topk_search_core #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned MAX_DIM     = 256,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire                           op_i,
  input  wire  [5:0]                    entry_i,
  input  wire  [7:0]                    element_i,
  input  wire  signed [15:0]            value_i,
  input  wire                           last_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [5:0]                    match_index_o,
  output logic signed [15:0]            score_o,
  output logic [5:0]                    rank_o,
  output logic                          final_res_o,
  input  wire                           cfg_we_i,
  input  wire  [cts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [8:0]                    cfg_data_i
);

  localparam int unsigned QIW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned IW  = (QIW > 4) ? QIW : 4;
  localparam int unsigned EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  cts_pkg::cmd_t  cmd;
  cts_pkg::stat_t stat;
  logic [IW-1:0]  elem_idx;
  logic [EW-1:0]  ent_idx;
  logic [5:0]     rank;

  cts_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_DIM    (MAX_DIM)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .element_i  (element_i),
    .last_i     (last_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .elem_idx_o (elem_idx),
    .ent_idx_o  (ent_idx),
    .rank_o     (rank)
  );

  cts_dp #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .elem_idx_i   (elem_idx),
    .ent_idx_i    (ent_idx),
    .rank_i       (rank),
    .entry_i      (entry_i),
    .element_i    (element_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .match_index_o(match_index_o),
    .score_o      (score_o),
    .rank_o       (rank_o),
    .final_res_o  (final_res_o)
  );

  // A search always stalls the input in the cycle after it is accepted.
  `CTS_ASSERT(a_search_stalls, clk_i, rst_ni, in_valid_i && !in_stall_o && op_i && last_i |=> in_stall_o)
  // Loads never start a search.
  `CTS_ASSERT(a_load_no_stall, clk_i, rst_ni, in_valid_i && !in_stall_o && !op_i |=> !in_stall_o)
  // A result is never pushed over one that is still waiting.
  `CTS_ASSERT_NEVER(a_emit_when_full, clk_i, rst_ni, cmd.emit && out_valid_o && out_stall_i)
  // The square root is never stepped after it finished.
  `CTS_ASSERT_NEVER(a_sqrt_overstep, clk_i, rst_ni, cmd.sqrt_step && stat.sqrt_done)

endmodule
`default_nettype wire

>>> design/cts_ctrl.sv
// Controller of the cosine top-k search: configuration registers, loop
// counters and the sequencing state machine. Depends on cts_pkg.
`default_nettype none
module cts_ctrl #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned MAX_DIM     = 256,
  localparam int unsigned QIW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int unsigned IW  = (QIW > 4) ? QIW : 4,
  localparam int unsigned EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire                           op_i,
  input  wire  [7:0]                    element_i,
  input  wire                           last_i,
  input  wire                           cfg_we_i,
  input  wire  [cts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [8:0]                    cfg_data_i,
  input  cts_pkg::stat_t                stat_i,
  output cts_pkg::cmd_t                 cmd_o,
  output logic [IW-1:0]                 elem_idx_o,
  output logic [EW-1:0]                 ent_idx_o,
  output logic [5:0]                    rank_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_QISS   = 4'd1;
  localparam logic [3:0] S_QDRN   = 4'd2;
  localparam logic [3:0] S_QSQ    = 4'd3;
  localparam logic [3:0] S_EISS   = 4'd4;
  localparam logic [3:0] S_EDRN   = 4'd5;
  localparam logic [3:0] S_VSQ    = 4'd6;
  localparam logic [3:0] S_DIVI   = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_WR     = 4'd9;
  localparam logic [3:0] S_RSTART = 4'd10;
  localparam logic [3:0] S_RSCAN  = 4'd11;
  localparam logic [3:0] S_RDRN   = 4'd12;
  localparam logic [3:0] S_EMIT   = 4'd13;

  logic [3:0]    state_q, state_d;
  logic [6:0]    ent_cnt_q, top_k_q;
  logic [8:0]    dim_q;
  logic [6:0]    n_q, n_d, k_q, k_d;
  logic          valid_q, valid_d;
  logic [IW-1:0] i_q, i_d;
  logic [EW-1:0] e_q, e_d;
  logic [5:0]    r_q, r_d;
  logic          in_acc, i_last, e_last, r_last, div_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);

  assign n_d = (int'(ent_cnt_q) > MAX_ENTRIES) ? 7'(MAX_ENTRIES) : ent_cnt_q;
  assign k_d = (top_k_q < n_d) ? top_k_q : n_d;
  assign valid_d = (dim_q != 9'd0) && (int'(dim_q) <= MAX_DIM) &&
                   (int'(element_i) + 1 == int'(dim_q));

  assign i_last   = (int'(i_q) == int'(dim_q) - 1);
  assign e_last   = (int'(e_q) == int'(n_q) - 1);
  assign r_last   = (int'(r_q) == int'(k_q) - 1);
  assign div_last = (int'(i_q) == cts_pkg::DIV_STEPS - 1);

  assign elem_idx_o = i_q;
  assign ent_idx_o  = e_q;
  assign rank_o     = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_cnt_q <= 7'd0;
      top_k_q   <= 7'd5;
      dim_q     <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cts_pkg::CFG_ENTRY_COUNT: ent_cnt_q <= cfg_data_i[6:0];
        cts_pkg::CFG_TOP_K:       top_k_q   <= cfg_data_i[6:0];
        cts_pkg::CFG_DIMENSION:   dim_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    e_d     = e_q;
    r_d     = r_q;
    cmd_o   = '0;
    cmd_o.force_zero = !valid_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.vec_we = in_acc && !op_i;
        cmd_o.qry_we = in_acc && op_i;
        if (in_acc && op_i && last_i) begin
          cmd_o.taken_clr = 1'b1;
          cmd_o.qn_clr    = 1'b1;
          cmd_o.acc_clr   = 1'b1;
          i_d = '0;
          e_d = '0;
          if (valid_d) begin
            state_d = S_QISS;
          end else if (n_d == 7'd0) begin
            state_d = S_RSTART;
          end else begin
            state_d = S_WR;
          end
        end
      end
      S_QISS: begin
        cmd_o.iss   = 1'b1;
        cmd_o.qmode = 1'b1;
        i_d = i_q + 1'b1;
        if (i_last) state_d = S_QDRN;
      end
      S_QDRN: begin
        cmd_o.qmode = 1'b1;
        if (!stat_i.acc_busy) begin
          cmd_o.sqrt_start = 1'b1;
          state_d = S_QSQ;
        end
      end
      S_QSQ: begin
        if (stat_i.sqrt_done) begin
          cmd_o.qroot_ld = 1'b1;
          cmd_o.acc_clr  = 1'b1;
          i_d = '0;
          e_d = '0;
          state_d = (n_q == 7'd0) ? S_RSTART : S_EISS;
        end else begin
          cmd_o.sqrt_step = 1'b1;
        end
      end
      S_EISS: begin
        cmd_o.iss = 1'b1;
        i_d = i_q + 1'b1;
        if (i_last) state_d = S_EDRN;
      end
      S_EDRN: begin
        if (!stat_i.acc_busy) begin
          cmd_o.sqrt_start = 1'b1;
          state_d = S_VSQ;
        end
      end
      S_VSQ: begin
        if (stat_i.sqrt_done) begin
          cmd_o.den_ld = 1'b1;
          state_d = S_DIVI;
        end else begin
          cmd_o.sqrt_step = 1'b1;
        end
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        i_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        i_d = i_q + 1'b1;
        if (div_last) state_d = S_WR;
      end
      S_WR: begin
        cmd_o.score_we = 1'b1;
        if (e_last) begin
          state_d = S_RSTART;
        end else begin
          e_d = e_q + 1'b1;
          i_d = '0;
          cmd_o.acc_clr = 1'b1;
          state_d = valid_q ? S_EISS : S_WR;
        end
      end
      S_RSTART: begin
        r_d = '0;
        e_d = '0;
        cmd_o.scan_clr = 1'b1;
        state_d = (k_q == 7'd0) ? S_IDLE : S_RSCAN;
      end
      S_RSCAN: begin
        cmd_o.scan_iss = 1'b1;
        e_d = e_q + 1'b1;
        if (e_last) state_d = S_RDRN;
      end
      S_RDRN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit      = 1'b1;
          cmd_o.final_res = r_last;
          if (r_last) begin
            state_d = S_IDLE;
          end else begin
            r_d = r_q + 1'b1;
            e_d = '0;
            cmd_o.scan_clr = 1'b1;
            state_d = S_RSCAN;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      e_q     <= '0;
      r_q     <= '0;
      n_q     <= 7'd0;
      k_q     <= 7'd0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      e_q     <= e_d;
      r_q     <= r_d;
      if (in_acc && op_i && last_i) begin
        n_q     <= n_d;
        k_q     <= k_d;
        valid_q <= valid_d;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/cts_dp.sv
// Datapath of the cosine top-k search: vector, query and score memories,
// multiply-accumulate pipeline, bit-serial square root and divider, ranking
// scan and output register. Depends on cts_pkg.
`default_nettype none
module cts_dp #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned MAX_DIM     = 256,
  parameter int unsigned VALUE_BITS  = 16,
  localparam int unsigned QIW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int unsigned IW  = (QIW > 4) ? QIW : 4,
  localparam int unsigned EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  cts_pkg::cmd_t        cmd_i,
  output cts_pkg::stat_t       stat_o,
  input  wire  [IW-1:0]        elem_idx_i,
  input  wire  [EW-1:0]        ent_idx_i,
  input  wire  [5:0]           rank_i,
  input  wire  [5:0]           entry_i,
  input  wire  [7:0]           element_i,
  input  wire  signed [15:0]   value_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [5:0]           match_index_o,
  output logic signed [15:0]   score_o,
  output logic [5:0]           rank_o,
  output logic                 final_res_o
);

  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned PW  = 2 * VB;
  localparam int unsigned VD  = MAX_ENTRIES * MAX_DIM;
  localparam int unsigned VAW = (VD > 1) ? $clog2(VD) : 1;
  localparam int unsigned ACC_RAW = PW + QIW + 1;
  localparam int unsigned ACC_W = (ACC_RAW > 64) ? 64 : ACC_RAW;
  localparam int unsigned SQ_STEPS = (ACC_W + 1) / 2;
  localparam int unsigned SW = 2 * SQ_STEPS;

  // Element conversion: low VALUE_BITS bits taken as two's complement.
  logic [31:0]          val_ext;
  logic signed [VB-1:0] elem_in;
  assign val_ext = {16'b0, value_i};
  always_comb begin
    for (int b = 0; b < VB; b++) begin
      elem_in[b] = val_ext[b];
    end
  end

  logic           vec_wr_ok, qry_wr_ok;
  logic [VAW-1:0] vec_wr_addr, vec_rd_addr;
  assign vec_wr_ok = cmd_i.vec_we && (int'(entry_i) < MAX_ENTRIES) &&
                     (int'(element_i) < MAX_DIM);
  assign qry_wr_ok = cmd_i.qry_we && (int'(element_i) < MAX_DIM);
  assign vec_wr_addr = VAW'(int'(entry_i) * MAX_DIM + int'(element_i));
  assign vec_rd_addr = VAW'(int'(ent_idx_i) * MAX_DIM + int'(elem_idx_i));

  logic signed [VB-1:0] vec_mem [VD];
  logic signed [VB-1:0] qry_mem [MAX_DIM];
  logic signed [VB-1:0] vec_rd_q, qry_rd_q;

  always_ff @(posedge clk_i) begin
    if (vec_wr_ok) vec_mem[vec_wr_addr] <= elem_in;
    if (cmd_i.iss) vec_rd_q <= vec_mem[vec_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (qry_wr_ok) qry_mem[QIW'(element_i)] <= elem_in;
    if (cmd_i.iss) qry_rd_q <= qry_mem[QIW'(elem_idx_i)];
  end

  // Multiply stage, then accumulate stage.
  logic                 vld1_q, vld2_q;
  logic signed [VB-1:0] mul_b;
  logic signed [PW-1:0] prod_a_d, prod_b_d, prod_a_q, prod_b_q;
  logic signed [ACC_W-1:0] dot_q;
  logic [ACC_W-1:0]     vn_q, qn_q;

  assign mul_b    = cmd_i.qmode ? qry_rd_q : vec_rd_q;
  assign prod_a_d = qry_rd_q * mul_b;
  assign prod_b_d = vec_rd_q * vec_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= cmd_i.iss;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld1_q) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
    end
    if (cmd_i.acc_clr) begin
      dot_q <= '0;
      vn_q  <= '0;
    end else if (vld2_q && !cmd_i.qmode) begin
      dot_q <= dot_q + ACC_W'(prod_a_q);
      vn_q  <= vn_q + ACC_W'(prod_b_q);
    end
    if (cmd_i.qn_clr) begin
      qn_q <= '0;
    end else if (vld2_q && cmd_i.qmode) begin
      qn_q <= qn_q + ACC_W'(prod_a_q);
    end
  end

  // Square root, one result bit per step.
  logic [SW-1:0] num_q, res_q, bit_q, trial;
  logic [SQ_STEPS-1:0] root, qroot_q;
  assign trial = res_q + bit_q;
  assign root  = res_q[SQ_STEPS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (cmd_i.sqrt_start) begin
      bit_q <= SW'(1) << (SW - 2);
    end else if (cmd_i.sqrt_step) begin
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      num_q <= cmd_i.qmode ? SW'(qn_q) : SW'(vn_q);
      res_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      if (num_q >= trial) begin
        num_q <= num_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  // Denominator and restoring division of |dot| * 2^15 by it.
  logic          qzero_q, vzero_q, neg_q, sat_q;
  logic [SW-1:0] den_q;
  logic [ACC_W-1:0] mag;
  logic [SW:0]   rem_q, rem_sh;
  logic [14:0]   quo_q;
  logic signed [15:0] score_d;

  assign mag    = dot_q[ACC_W-1] ? ACC_W'(-dot_q) : ACC_W'(dot_q);
  assign rem_sh = {rem_q[SW-1:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.qroot_ld) begin
      qroot_q <= root;
      qzero_q <= (qn_q == '0);
    end
    if (cmd_i.den_ld) begin
      den_q   <= qroot_q * root;
      vzero_q <= (vn_q == '0);
    end
    if (cmd_i.div_init) begin
      neg_q <= dot_q[ACC_W-1];
      sat_q <= (SW'(mag) >= den_q);
      rem_q <= {1'b0, SW'(mag)};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[13:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[13:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (cmd_i.force_zero || qzero_q || vzero_q || (den_q == '0)) begin
      score_d = '0;
    end else if (sat_q) begin
      score_d = neg_q ? cts_pkg::SCORE_MIN : cts_pkg::SCORE_MAX;
    end else if (neg_q) begin
      score_d = -$signed({1'b0, quo_q});
    end else begin
      score_d = $signed({1'b0, quo_q});
    end
  end

  // Score memory and ranking scan; ties keep the earlier (lower) entry.
  logic signed [15:0] score_mem [MAX_ENTRIES];
  logic signed [15:0] score_rd_q, best_s_q;
  logic               sv1_q, found_q;
  logic [EW-1:0]      se1_q, best_e_q;
  logic [MAX_ENTRIES-1:0] taken_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.score_we) score_mem[ent_idx_i] <= score_d;
    if (cmd_i.scan_iss) begin
      score_rd_q <= score_mem[ent_idx_i];
      se1_q      <= ent_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv1_q   <= 1'b0;
      found_q <= 1'b0;
      taken_q <= '0;
    end else begin
      sv1_q <= cmd_i.scan_iss;
      if (cmd_i.scan_clr) begin
        found_q <= 1'b0;
      end else if (sv1_q && !taken_q[se1_q] && (!found_q || score_rd_q > best_s_q)) begin
        found_q <= 1'b1;
      end
      if (cmd_i.taken_clr) begin
        taken_q <= '0;
      end else if (cmd_i.emit) begin
        taken_q[best_e_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!cmd_i.scan_clr && sv1_q && !taken_q[se1_q] &&
        (!found_q || score_rd_q > best_s_q)) begin
      best_e_q <= se1_q;
      best_s_q <= score_rd_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      match_index_o <= 6'(best_e_q);
      score_o       <= best_s_q;
      rank_o        <= rank_i;
      final_res_o   <= cmd_i.final_res;
    end
  end

  assign stat_o.acc_busy  = vld1_q || vld2_q;
  assign stat_o.sqrt_done = (bit_q == '0);
  assign stat_o.out_busy  = out_valid_o && out_stall_i;

endmodule
`default_nettype wire
